[src/mbt_pkg.sv]
package mbt_pkg;

	localparam int HIDDEN_UNITS_DEF = 10;
	localparam int INPUT_UNITS_DEF  = 2;
	localparam int SIG_ENTRIES_DEF  = 256;

	localparam int ACT_W = 13;
	localparam int W_W   = 24;
	localparam int X_W   = 16;
	localparam int LR_W  = 16;

	localparam logic [LR_W-1:0]  LR_RESET = 16'd655;
	localparam logic [ACT_W-1:0] ONE_Q12  = 13'd4096;

	localparam logic [1:0] CMD_INFER = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FWD,
		ST_OUT,
		ST_BWD
	} mbt_state_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic signed [X_W-1:0]  in_first;
		logic signed [X_W-1:0]  in_second;
		logic [ACT_W-1:0]       target_value;
		logic [5:0]             param_index;
		logic signed [W_W-1:0]  param_value;
	} mbt_item_t;

	typedef struct packed {
		logic [ACT_W-1:0] prediction;
		logic [ACT_W-1:0] abs_error;
	} mbt_result_t;

	// one hidden unit's parameters plus its last activation
	typedef struct packed {
		logic signed [W_W-1:0] wh0;
		logic signed [W_W-1:0] wh1;
		logic signed [W_W-1:0] bh;
		logic signed [W_W-1:0] wo;
		logic [ACT_W-1:0]      h;
	} mbt_unit_t;

	typedef struct packed {
		logic shift;
		logic wr_wh0;
		logic wr_wh1;
		logic wr_bh;
		logic wr_wo;
	} mbt_cell_ctl_t;

endpackage

[src/mbt_cell.sv]
module mbt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mbt_pkg::mbt_cell_ctl_t     ctl,
	input  mbt_pkg::mbt_unit_t         shift_in,
	input  logic signed [23:0]         wr_value,
	output mbt_pkg::mbt_unit_t         unit
);
	import mbt_pkg::*;

	mbt_unit_t unit_q;

	// shift takes priority; writes only happen with the ring at home
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= '0;
		end else if (ctl.shift) begin
			unit_q <= shift_in;
		end else begin
			if (ctl.wr_wh0) unit_q.wh0 <= wr_value;
			if (ctl.wr_wh1) unit_q.wh1 <= wr_value;
			if (ctl.wr_bh)  unit_q.bh  <= wr_value;
			if (ctl.wr_wo)  unit_q.wo  <= wr_value;
		end
	end

	assign unit = unit_q;

endmodule

[src/mbt_sigmoid.sv]
module mbt_sigmoid #(
	parameter int ENTRIES = mbt_pkg::SIG_ENTRIES_DEF,
	parameter int Z_W     = 30
) (
	input  logic                           clk,
	input  logic signed [Z_W-1:0]          z,
	output logic [mbt_pkg::ACT_W-1:0]      act
);
	import mbt_pkg::*;

	localparam int IW   = $clog2(ENTRIES + 1);
	localparam int P_W  = 21 + IW;
	localparam int HALF = 524288;
	localparam logic [63:0] EXP_ONE = 64'd1580030169;
	localparam logic signed [Z_W-1:0] Z_HI = Z_W'(HALF);
	localparam logic signed [Z_W-1:0] Z_LO = Z_W'(-HALF);

	// restoring long division, used only while the table is built
	function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-a/2^16) in Q.32, 16-term series on the fraction, then whole steps
	function automatic logic [63:0] exp_neg(input logic [63:0] a);
		logic [63:0]        n;
		logic [63:0]        f;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		n    = a >> 16;
		f    = a & 64'hFFFF;
		term = 64'd4294967296;
		sum  = 64'sd4294967296;
		for (int i = 1; i <= 16; i++) begin
			term = cdiv(term * f, 64'd65536 * 64'(i));
			if ((i & 1) == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		v = $unsigned(sum);
		for (int j = 0; j < 8; j++) begin
			if (64'(j) < n)
				v = (v * EXP_ONE + 64'd2147483648) >> 32;
		end
		return v;
	endfunction

	function automatic logic [ENTRIES:0][ACT_W-1:0] build_tab();
		logic [ENTRIES:0][ACT_W-1:0] tab;
		logic [63:0]                 num;
		logic [63:0]                 nn;
		logic [63:0]                 a;
		logic [63:0]                 d;
		logic [63:0]                 pv;
		logic signed [63:0]          s;
		nn = 64'(ENTRIES);
		for (int k = 0; k <= ENTRIES; k++) begin
			num = 64'(k) * 64'd2097152 + nn;
			s   = $signed(cdiv(num, 64'd2 * nn)) - 64'sd524288;
			a   = (s < 0) ? $unsigned(-s) : $unsigned(s);
			d   = 64'd4294967296 + exp_neg(a);
			pv  = cdiv(64'd35184372088832 + d, 64'd2 * d);
			tab[k] = (s >= 0) ? ACT_W'(pv) : ACT_W'(64'd4096 - pv);
		end
		return tab;
	endfunction

	localparam logic [ENTRIES:0][ACT_W-1:0] SIG_TAB = build_tab();

	logic signed [Z_W-1:0] zc;
	logic [20:0]           off;
	logic [P_W-1:0]        p;
	logic [IW-1:0]         idx;
	logic [ACT_W-1:0]      lo;
	logic [ACT_W-1:0]      hi;
	logic signed [34:0]    interp;

	logic [ACT_W-1:0]      lo_s1;
	logic signed [13:0]    diff_s1;
	logic [19:0]           frac_s1;
	logic [ACT_W-1:0]      act_s2;

	// clamp to +-8, place on the table grid
	always_comb begin
		if (z > Z_HI)
			zc = Z_HI;
		else if (z < Z_LO)
			zc = Z_LO;
		else
			zc = z;
		off = 21'(zc - Z_LO);
		p   = P_W'(off) * P_W'(ENTRIES);
		idx = p[20 +: IW];
		lo  = SIG_TAB[idx];
		hi  = (int'(idx) >= ENTRIES) ? lo : SIG_TAB[IW'(idx + 1'b1)];
	end

	always_ff @(posedge clk) begin
		lo_s1   <= lo;
		diff_s1 <= $signed({1'b0, hi}) - $signed({1'b0, lo});
		frac_s1 <= p[19:0];
	end

	assign interp = 35'(diff_s1) * 35'($signed({1'b0, frac_s1}));

	always_ff @(posedge clk) begin
		act_s2 <= ACT_W'($signed({1'b0, lo_s1}) + 14'(interp >>> 20));
	end

	assign act = act_s2;

endmodule

[src/mlp_backprop_train_step_unit.sv]
// Two-input perceptron with one hidden sigmoid layer and a sigmoid output,
// trained in place by one backpropagation SGD step per train command.
//
// Command channel: an item transfers on a clock edge with start high and
// busy low. cmd selects infer, train or a parameter write.
// Result channel: done pulses for one cycle with prediction and abs_error
// on result; there is no back-pressure, the receiver must take it.
// Learning-rate channel: cfg_data transfers when cfg_valid is high
// (cfg_ready is always high); write it only while the block is idle.
//
// Datapath, H hidden units: the unit parameters sit in a ring of H cells that
// rotates past one shared multiply/sigmoid datapath at the head cell.
// The forward pass steps through each unit in turn (two input products, bias
// sum, two-stage sigmoid table, output product, accumulate), then through the
// output sigmoid, after which done rises.
// Train then computes the output delta and bias update, and then the
// backward update of each unit, keeping busy high throughout.
// Write and the unused command give an all-zero result the next cycle and
// leave busy low.
// Reset clears every weight and bias to zero and the learning rate to 655.
module mlp_backprop_train_step_unit #(
	parameter int HIDDEN_UNITS          = mbt_pkg::HIDDEN_UNITS_DEF,
	parameter int INPUT_UNITS           = mbt_pkg::INPUT_UNITS_DEF,
	parameter int SIGMOID_TABLE_ENTRIES = mbt_pkg::SIG_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mbt_pkg::mbt_item_t    item,
	output logic                  done,
	output mbt_pkg::mbt_result_t  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	import mbt_pkg::*;

	localparam int NH    = INPUT_UNITS * HIDDEN_UNITS;
	localparam int UW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int OUT_W = 26 + $clog2(HIDDEN_UNITS + 1);
	// wide enough for a hidden sum and for the output sum
	localparam int ACC_W = (OUT_W > 30) ? OUT_W : 30;
	localparam int DH_W  = 29;

	// forward steps per unit
	localparam logic [2:0] FS_W0  = 3'd0;
	localparam logic [2:0] FS_W1  = 3'd1;
	localparam logic [2:0] FS_Z   = 3'd2;
	localparam logic [2:0] FS_SG1 = 3'd3;
	localparam logic [2:0] FS_SG2 = 3'd4;
	localparam logic [2:0] FS_OWT = 3'd5;
	localparam logic [2:0] FS_ACC = 3'd6;
	// output steps
	localparam logic [2:0] OS_LD  = 3'd0;
	localparam logic [2:0] OS_Y   = 3'd3;
	localparam logic [2:0] OS_DO  = 3'd4;
	localparam logic [2:0] OS_BP  = 3'd5;
	localparam logic [2:0] OS_BO  = 3'd6;
	// backward steps per unit
	localparam logic [2:0] BS_M0  = 3'd0;
	localparam logic [2:0] BS_M1  = 3'd1;
	localparam logic [2:0] BS_M2  = 3'd2;
	localparam logic [2:0] BS_M3  = 3'd3;
	localparam logic [2:0] BS_M4  = 3'd4;
	localparam logic [2:0] BS_SH  = 3'd5;

	localparam logic signed [64:0] W_MAX65 = 65'sd8388607;
	localparam logic signed [64:0] W_MIN65 = -65'sd8388608;

	function automatic logic signed [W_W-1:0] sat_add(input logic signed [W_W-1:0] w,
		input logic signed [63:0] d);
		logic signed [64:0] s;
		s = 65'(w) + 65'(d);
		if (s > W_MAX65)
			s = W_MAX65;
		else if (s < W_MIN65)
			s = W_MIN65;
		return W_W'(s);
	endfunction

	// round half up, then arithmetic shift
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic [10:0] deriv(input logic [ACT_W-1:0] a);
		logic [25:0] pr;
		pr = 26'(a) * 26'(ONE_Q12 - a);
		return pr[22:12];
	endfunction

	mbt_state_t state_q, state_d;
	logic [2:0]  step_q, step_d;
	logic [UW-1:0] unit_q, unit_d;
	logic accept, wr_en, ring_shift, emit, done_q;

	logic [1:0]              cmd_q;
	logic signed [X_W-1:0]   x0_q, x1_q;
	logic [ACT_W-1:0]        t_q;
	logic [LR_W-1:0]         lr_q;
	logic signed [W_W-1:0]   bo_q;
	logic signed [ACC_W-1:0] z_q, acc_q;
	logic signed [39:0]      prod_q;
	logic [ACT_W-1:0]        h_q;
	logic [10:0]             der_q, hder_q;
	logic signed [13:0]      err_q;
	logic signed [23:0]      do_q;
	logic signed [40:0]      bo_prod_q;
	logic signed [47:0]      m1_q;
	logic signed [37:0]      m2_q;
	logic signed [43:0]      dhp_q;
	logic signed [54:0]      m2lr_q;
	logic signed [DH_W-1:0]  dh_q;
	logic signed [45:0]      lrdh_q;
	logic signed [61:0]      pw0_q, pw1_q;
	logic signed [W_W-1:0]   wo_new_q, bh_new_q;
	mbt_result_t             result_q;

	logic [ACT_W-1:0]        act;
	logic signed [13:0]      err_c;
	logic [ACT_W-1:0]        abs_c;

	mbt_unit_t     units [HIDDEN_UNITS];
	mbt_unit_t     chain [HIDDEN_UNITS];
	mbt_cell_ctl_t ctls  [HIDDEN_UNITS];
	mbt_unit_t     head_next;

	assign accept    = start && (state_q == ST_IDLE);
	assign wr_en     = accept && (item.cmd == CMD_WRITE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			unit_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			unit_q  <= unit_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		unit_d     = unit_q;
		ring_shift = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.cmd == CMD_INFER || item.cmd == CMD_TRAIN)) begin
					state_d = ST_FWD;
					step_d  = FS_W0;
					unit_d  = '0;
				end
			end
			ST_FWD: begin
				if (step_q == FS_ACC) begin
					ring_shift = 1'b1;
					step_d     = FS_W0;
					if (unit_q == UW'(HIDDEN_UNITS - 1)) begin
						state_d = ST_OUT;
						step_d  = OS_LD;
						unit_d  = '0;
					end else begin
						unit_d = unit_q + UW'(1);
					end
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			ST_OUT: begin
				step_d = step_q + 3'd1;
				if (step_q == OS_Y) begin
					emit = 1'b1;
					if (cmd_q != CMD_TRAIN) begin
						state_d = ST_IDLE;
						step_d  = '0;
					end
				end else if (step_q == OS_BO) begin
					state_d = ST_BWD;
					step_d  = BS_M0;
				end
			end
			ST_BWD: begin
				if (step_q == BS_SH) begin
					ring_shift = 1'b1;
					step_d     = BS_M0;
					if (unit_q == UW'(HIDDEN_UNITS - 1)) begin
						state_d = ST_IDLE;
						unit_d  = '0;
					end else begin
						unit_d = unit_q + UW'(1);
					end
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			lr_q   <= LR_RESET;
			bo_q   <= '0;
		end else begin
			done_q <= emit || (accept && item.cmd != CMD_INFER && item.cmd != CMD_TRAIN);
			if (cfg_valid)
				lr_q <= cfg_data;
			if (wr_en && int'(item.param_index) == NH + 2 * HIDDEN_UNITS)
				bo_q <= item.param_value;
			else if (state_q == ST_OUT && step_q == OS_BO)
				bo_q <= sat_add(bo_q, rnd_shr(64'(bo_prod_q), 24));
		end
	end

	// ---------------- shared datapath at the head cell ----------------
	assign err_c = $signed({1'b0, t_q}) - $signed({1'b0, act});
	assign abs_c = (err_c < 0) ? ACT_W'(-err_c) : ACT_W'(err_c);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.cmd;
			x0_q     <= item.in_first;
			x1_q     <= (INPUT_UNITS == 2) ? item.in_second : '0;
			t_q      <= (item.target_value > ONE_Q12) ? ONE_Q12 : item.target_value;
			acc_q    <= ACC_W'(bo_q);
			result_q <= '0;
		end
		case (state_q)
			ST_FWD: begin
				case (step_q)
					FS_W0: begin
						prod_q <= 40'(x0_q) * 40'(units[0].wh0);
						z_q    <= ACC_W'(units[0].bh);
					end
					FS_W1: begin
						prod_q <= 40'(x1_q) * 40'(units[0].wh1);
						z_q    <= z_q + ACC_W'(prod_q >>> 12);
					end
					FS_Z:  z_q <= z_q + ACC_W'(prod_q >>> 12);
					FS_OWT: begin
						h_q    <= act;
						prod_q <= 40'($signed({1'b0, act})) * 40'(units[0].wo);
					end
					FS_ACC: acc_q <= acc_q + ACC_W'(prod_q >>> 12);
					default: ;
				endcase
			end
			ST_OUT: begin
				case (step_q)
					OS_LD: z_q <= acc_q;
					OS_Y: begin
						result_q.prediction <= act;
						result_q.abs_error  <= (cmd_q == CMD_TRAIN) ? abs_c : '0;
						der_q <= deriv(act);
						err_q <= err_c;
					end
					OS_DO: do_q <= 24'(err_q) * 24'($signed({1'b0, der_q}));
					OS_BP: bo_prod_q <= 41'(do_q) * 41'($signed({1'b0, lr_q}));
					default: ;
				endcase
			end
			ST_BWD: begin
				case (step_q)
					BS_M0: begin
						m1_q   <= 48'(do_q) * 48'(units[0].wo);
						m2_q   <= 38'(do_q) * 38'($signed({1'b0, units[0].h}));
						hder_q <= deriv(units[0].h);
					end
					BS_M1: begin
						dhp_q  <= 44'(m1_q >>> 16) * 44'($signed({1'b0, hder_q}));
						m2lr_q <= 55'(m2_q) * 55'($signed({1'b0, lr_q}));
					end
					BS_M2: begin
						dh_q     <= DH_W'(dhp_q >>> 12);
						wo_new_q <= sat_add(units[0].wo, rnd_shr(64'(m2lr_q), 36));
					end
					BS_M3: lrdh_q <= 46'(dh_q) * 46'($signed({1'b0, lr_q}));
					BS_M4: begin
						pw0_q    <= 62'(lrdh_q) * 62'(x0_q);
						pw1_q    <= 62'(lrdh_q) * 62'(x1_q);
						bh_new_q <= sat_add(units[0].bh, rnd_shr(64'(lrdh_q), 24));
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// value re-entering the tail of the ring
	always_comb begin
		head_next = units[0];
		if (state_q == ST_FWD) begin
			head_next.h = h_q;
		end else begin
			head_next.wh0 = sat_add(units[0].wh0, rnd_shr(64'(pw0_q), 36));
			if (INPUT_UNITS == 2)
				head_next.wh1 = sat_add(units[0].wh1, rnd_shr(64'(pw1_q), 36));
			head_next.bh = bh_new_q;
			head_next.wo = wo_new_q;
		end
	end

	// ---------------- ring of unit cells ----------------
	for (genvar k = 0; k < HIDDEN_UNITS; k++) begin : g_cell
		always_comb begin
			ctls[k].shift  = ring_shift;
			ctls[k].wr_wh0 = wr_en && (int'(item.param_index) == k);
			ctls[k].wr_wh1 = wr_en && (INPUT_UNITS == 2)
				&& (int'(item.param_index) == HIDDEN_UNITS + k);
			ctls[k].wr_bh  = wr_en && (int'(item.param_index) == NH + k);
			ctls[k].wr_wo  = wr_en && (int'(item.param_index) == NH + HIDDEN_UNITS + k);
		end

		if (k == HIDDEN_UNITS - 1) begin : g_tail
			assign chain[k] = head_next;
		end else begin : g_mid
			assign chain[k] = units[k + 1];
		end

		mbt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctls[k]),
			.shift_in (chain[k]),
			.wr_value (item.param_value),
			.unit     (units[k])
		);
	end

	mbt_sigmoid #(
		.ENTRIES (SIGMOID_TABLE_ENTRIES),
		.Z_W     (ACC_W)
	) u_sigmoid (
		.clk (clk),
		.z   (z_q),
		.act (act)
	);

	// ---------------- checks ----------------
	a_no_shift_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ring_shift)
		else $error("ring rotated while idle");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_q <= UW'(HIDDEN_UNITS - 1))
		else $error("unit counter out of range");

	a_accept_follow: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("command transfer had no effect");

	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.prediction <= ONE_Q12)
		else $error("prediction above one");

endmodule

[tb/mlp_backprop_train_step_unit_tb.sv]
`timescale 1ns / 100ps

module mlp_backprop_train_step_unit_tb;
	import mbt_pkg::*;

	localparam int NH = 10;               // hidden units
	localparam int NSIG = 256;            // sigmoid table intervals
	localparam int IDX_BH0 = 2 * NH;      // first hidden bias
	localparam int IDX_WO0 = 3 * NH;      // first output weight
	localparam int IDX_BO = 4 * NH;       // output bias
	localparam int ITEM_W = $bits(mbt_item_t);
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint SPAN = 64'd1048576;
	localparam longint HALF = 64'd524288;
	localparam longint WMAX = 64'd8388607;
	localparam longint WMIN = -64'sd8388608;
	localparam int DRAIN = 150;           // covers the busy time of a train command

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mbt_item_t item = '0;
	logic done;
	mbt_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	mlp_backprop_train_step_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Network shadow, updated as each command transfers
	longint wh[2*NH];
	longint bh[NH];
	longint wo[NH];
	longint bo;
	longint lrate;
	longint sig_tab[NSIG+1];

	mbt_item_t pending[$];          // commands still to be sent
	mbt_result_t awaited[$];        // predicted results, oldest first
	bit calm = 1'b0;                // no sender idling while set
	int errors = 0;

	// exp(-a/65536) in Q.32, series on the fraction then whole steps of e^-1
	function automatic longint unsigned exp_neg(longint unsigned a);
		longint unsigned n, f, term, v;
		longint sum;
		n = a >> 16;
		f = a & 64'hFFFF;
		term = 64'd1 << 32;
		sum = 64'sd1 << 32;
		for (int i = 1; i <= 16; i++) begin
			term = term * f / (64'd65536 * i);
			if (i % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		v = longint'(sum);
		for (longint unsigned i = 0; i < n; i++)
			v = (v * 64'd1580030169 + (64'd1 << 31)) >> 32;
		return v;
	endfunction

	function automatic void fill_sigmoid();
		longint s;
		longint unsigned a, d, p;
		for (int k = 0; k <= NSIG; k++) begin
			s = (2 * k * SPAN + NSIG) / (2 * NSIG) - HALF;
			a = (s < 0) ? -s : s;
			d = (64'd1 << 32) + exp_neg(a);
			p = ((64'd4096 << 33) + d) / (2 * d);
			sig_tab[k] = (s >= 0) ? longint'(p) : 4096 - longint'(p);
		end
	endfunction

	function automatic longint sigmoid(longint z);
		longint p, idx, frac;
		if (z > HALF) z = HALF;
		if (z < -HALF) z = -HALF;
		p = (z + HALF) * NSIG;
		idx = p / SPAN;
		frac = p % SPAN;
		if (idx >= NSIG) return sig_tab[NSIG];
		return sig_tab[idx] + (((sig_tab[idx+1] - sig_tab[idx]) * frac) >>> 20);
	endfunction

	function automatic longint slope(longint a);
		return (a * (4096 - a)) >>> 12;
	endfunction

	function automatic longint sat(longint v);
		return (v > WMAX) ? WMAX : (v < WMIN) ? WMIN : v;
	endfunction

	function automatic longint rnd(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// Applies a write, or runs the forward pass plus one SGD step for train; returns the result the block owes
	function automatic mbt_result_t run_network(mbt_item_t c);
		mbt_result_t r;
		longint x[2], h[NH];
		longint z, acc, y, t, err, d_o, d_h;
		int idx;
		r = '0;
		x[0] = c.in_first;
		x[1] = c.in_second;
		if (c.cmd == CMD_WRITE) begin
			idx = c.param_index;
			if (idx < IDX_BH0) wh[idx] = c.param_value;
			else if (idx < IDX_WO0) bh[idx-IDX_BH0] = c.param_value;
			else if (idx < IDX_BO) wo[idx-IDX_WO0] = c.param_value;
			else if (idx == IDX_BO) bo = c.param_value;
			return r;
		end
		if (c.cmd == CMD_UNUSED) return r;
		acc = bo;
		for (int i = 0; i < NH; i++) begin
			z = bh[i];
			for (int j = 0; j < 2; j++) z += (x[j] * wh[j*NH+i]) >>> 12;
			h[i] = sigmoid(z);
			acc += (h[i] * wo[i]) >>> 12;
		end
		y = sigmoid(acc);
		r.prediction = y[12:0];
		if (c.cmd == CMD_INFER) return r;
		t = (c.target_value > 4096) ? 4096 : c.target_value;
		err = t - y;
		r.abs_error = ACT_W'((err < 0) ? -err : err);
		d_o = err * slope(y);
		for (int i = 0; i < NH; i++) begin
			// hidden delta uses the output weight before its update
			d_h = (((d_o * wo[i]) >>> 16) * slope(h[i])) >>> 12;
			wo[i] = sat(wo[i] + rnd(lrate * (d_o * h[i]), 36));
			for (int j = 0; j < 2; j++)
				wh[j*NH+i] = sat(wh[j*NH+i] + rnd(lrate * (d_h * x[j]), 36));
			bh[i] = sat(bh[i] + rnd(lrate * d_h, 24));
		end
		bo = sat(bo + rnd(lrate * d_o, 24));
		return r;
	endfunction

	// Command driver: start held while an item waits, dropped on random idles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited.push_back(run_network(item));
				void'(pending.pop_front());
			end
			if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
				start <= 1'b1;
				item <= pending[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: one transfer per done pulse, no back-pressure possible
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result pred=%0d err=%0d", result.prediction,
						result.abs_error);
			end else begin
				if (result !== awaited[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp pred=%0d err=%0d, got pred=%0d err=%0d",
							awaited[0].prediction, awaited[0].abs_error,
							result.prediction, result.abs_error);
				end
				void'(awaited.pop_front());
			end
		end
	end

	function automatic mbt_item_t make_cmd(logic [1:0] c, int a, int b, int t, int idx, int v);
		mbt_item_t m;
		m.cmd = c;
		m.in_first = X_W'(a);
		m.in_second = X_W'(b);
		m.target_value = ACT_W'(t);
		m.param_index = 6'(idx);
		m.param_value = W_W'(v);
		return m;
	endfunction

	// Random content, mostly meaningful weights and train/infer traffic
	function automatic mbt_item_t random_cmd();
		mbt_item_t m;
		int pick;
		m = mbt_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
		pick = $urandom_range(0, 99);
		if (pick < 40) m.cmd = CMD_TRAIN;
		else if (pick < 65) m.cmd = CMD_INFER;
		else if (pick < 95) m.cmd = CMD_WRITE;
		else m.cmd = CMD_UNUSED;
		if ($urandom_range(0, 3) != 0) begin
			m.in_first = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			m.in_second = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
		end
		if ($urandom_range(0, 7) != 0) m.target_value = ACT_W'($urandom_range(0, 4096));
		if ($urandom_range(0, 9) != 0) m.param_index = 6'($urandom_range(0, IDX_BO));
		if ($urandom_range(0, 3) != 0)
			m.param_value = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
		return m;
	endfunction

	task automatic settle();
		while (pending.size() > 0 || awaited.size() > 0 || start) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Learning-rate transfer, only with the block idle
	task automatic set_rate(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		lrate = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] rates[5];
		for (int i = 0; i < 2*NH; i++) wh[i] = 0;
		for (int i = 0; i < NH; i++) begin
			bh[i] = 0;
			wo[i] = 0;
		end
		bo = 0;
		lrate = LR_RESET;
		fill_sigmoid();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero network, extreme fields, out-of-range writes, spare command
		pending.push_back(make_cmd(CMD_INFER, 32767, -32768, 0, 0, 0));
		pending.push_back(make_cmd(CMD_TRAIN, 0, 0, 8191, 0, 0));
		pending.push_back(make_cmd(CMD_TRAIN, 0, 0, 0, 0, 0));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, 0, 8388607));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, NH, -8388608));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, IDX_BH0, 8388607));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, IDX_WO0, -8388608));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, IDX_WO0 + 1, 8388607));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, IDX_BO, 65536));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, IDX_BO + 1, 12345));
		pending.push_back(make_cmd(CMD_WRITE, 0, 0, 0, 63, -1));
		pending.push_back(make_cmd(CMD_UNUSED, 100, 200, 300, 5, 777));
		pending.push_back(make_cmd(CMD_INFER, 32767, 32767, 4096, 0, 0));
		pending.push_back(make_cmd(CMD_TRAIN, -32768, -32768, 4096, 0, 0));
		pending.push_back(make_cmd(CMD_TRAIN, 4096, -4096, 4097, 0, 0));
		pending.push_back(make_cmd(CMD_TRAIN, 32767, -32768, 0, 0, 0));
		pending.push_back(make_cmd(CMD_INFER, 0, 0, 0, 0, 0));
		settle();

		// phases at several rates, the second one without sender idles
		rates[0] = 16'hFFFF;
		rates[1] = 16'h0000;
		rates[2] = 16'd655;
		rates[3] = 16'($urandom);
		rates[4] = 16'h5555 ^ 16'($urandom_range(0, 1));
		for (int ph = 0; ph < 5; ph++) begin
			set_rate(ph == 4 ? ~rates[4] : rates[ph]);
			calm = (ph == 1);
			for (int n = 0; n < 107; n++) pending.push_back(random_cmd());
			settle();
		end

		if (errors == 0) begin
			$display("[mlp_backprop_train_step_unit] OK");
		end else begin
			$display("[mlp_backprop_train_step_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("[mlp_backprop_train_step_unit] ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/mbt_pkg.sv
src/mbt_cell.sv
src/mbt_sigmoid.sv
src/mlp_backprop_train_step_unit.sv
tb/mlp_backprop_train_step_unit_tb.sv
